// File: sv/rrsp_pkg.sv
// shared types and constants for the resp reply stream parser
package rrsp_pkg;

   localparam int MaxDepth = 8;
   localparam int DepthW = 4;
   localparam int SlotW = 3;

   localparam logic [26:0] BULK_LIMIT_RESET = 27'd67108864;
   localparam logic [19:0] ARRAY_LIMIT_RESET = 20'd1000000;

   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [63:0] INT_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic CSR_MAX_BULK = 1'b0;
   localparam logic CSR_MAX_ARRAY = 1'b1;

   typedef enum logic [2:0] {
      ROLE_TAG = 3'd0,
      ROLE_CONTENT = 3'd1,
      ROLE_HELD_CR = 3'd2,
      ROLE_TERM = 3'd3,
      ROLE_BULK = 3'd4,
      ROLE_TRAIL = 3'd5,
      ROLE_DISCARD = 3'd6
   } role_type;

   typedef enum logic [2:0] {
      EV_NONE = 3'd0,
      EV_SIMPLE_END = 3'd1,
      EV_ERROR_END = 3'd2,
      EV_INTEGER = 3'd3,
      EV_BULK_START = 3'd4,
      EV_BULK_END = 3'd5,
      EV_NIL = 3'd6,
      EV_ARRAY_START = 3'd7
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0,
      ERR_EMPTY = 3'd1,
      ERR_BAD_INT = 3'd2,
      ERR_BAD_BULK = 3'd3,
      ERR_BAD_ARRAY = 3'd4,
      ERR_UNKNOWN_TAG = 3'd5,
      ERR_TOO_DEEP = 3'd6
   } error_type;

   typedef enum logic [2:0] {
      KIND_NONE = 3'd0,
      KIND_SIMPLE = 3'd1,
      KIND_ERROR = 3'd2,
      KIND_INT = 3'd3,
      KIND_BULK = 3'd4,
      KIND_ARRAY = 3'd5,
      KIND_CRTAG = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      PH_TAG = 3'd0,
      PH_LINE = 3'd1,
      PH_BULK = 3'd2,
      PH_TRAIL = 3'd3,
      PH_ERR = 3'd4
   } phase_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP,
      ST_EMIT0,
      ST_EMIT1
   } state_type;

   // what the controller asks the datapath to do
   typedef struct packed {
      logic load;      // capture input byte
      logic decode;    // run the byte decode, compute result(s)
      logic pop;       // one stack count step
      logic out_sel;   // which of the two results to present
   } cmd_type;

   // what the datapath tells the controller
   typedef struct packed {
      logic two;       // this byte yields two results
      logic need_pop;  // an element completed, stack walk pending
      logic pop_more;  // stack walk not finished
   } sts_type;

   // one result item
   typedef struct packed {
      role_type role;
      logic [7:0] content;
      event_type ev;
      logic [63:0] value;
      logic [3:0] depth;
      logic [3:0] closed;
      logic done;
      error_type err;
   } result_type;

endpackage

// File: sv/resp_reply_stream_parser.sv
// top level of the resp reply stream parser
//  channel  direction  handshake              payload
//  req      in         req_valid/req_stall    req_stream_byte
//  rsp      out        rsp_valid/rsp_stall    role, content, event, depth, status
//  csr      in         csr_write              csr_index, csr_data
// each byte passes through a decode state, then one emit state per result
// a completed element that closes arrays adds a stack walk state, one count step
// per stack entry visited, made by the single-ported count stack walk
// reset is synchronous, clears parser state and restores the limit registers
// a stalled result holds; the next byte is taken in the cycle the last result leaves
module resp_reply_stream_parser import rrsp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_stream_byte,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [2:0] rsp_byte_role,
   output logic [7:0] rsp_content_byte,
   output logic [2:0] rsp_event_res,
   output logic signed [63:0] rsp_event_value,
   output logic [3:0] rsp_element_depth,
   output logic [3:0] rsp_arrays_closed,
   output logic rsp_reply_done,
   output logic [2:0] rsp_error_code,
   output logic rsp_last,
   input logic csr_write,
   input logic [0:0] csr_index,
   input logic [26:0] csr_data
);

   cmd_type cmd;
   sts_type sts;
   result_type rsp;

   rrsp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .rsp_last, .cmd, .sts
   );

   rrsp_datapath u_dp (
      .clock, .reset, .req_stream_byte, .csr_write, .csr_index, .csr_data,
      .cmd, .sts, .rsp
   );

   // result fields
   assign rsp_byte_role = rsp.role;
   assign rsp_content_byte = rsp.content;
   assign rsp_event_res = rsp.ev;
   assign rsp_event_value = rsp.value;
   assign rsp_element_depth = rsp.depth;
   assign rsp_arrays_closed = rsp.closed;
   assign rsp_reply_done = rsp.done;
   assign rsp_error_code = rsp.err;

endmodule

// File: sv/rrsp_ctrl.sv
// controller state machine for the resp reply stream parser
module rrsp_ctrl import rrsp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic rsp_last,
   output cmd_type cmd,
   input sts_type sts
);

   state_type state_ff, state_in;
   logic two_ff, two_in;

   // next state
   always_comb begin
      state_in = state_ff;
      two_in = two_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            two_in = sts.two;
            if (sts.need_pop) state_in = ST_POP;
            else state_in = sts.two ? ST_EMIT0 : ST_EMIT1;
         end
         ST_POP: begin
            if (!sts.pop_more) state_in = two_ff ? ST_EMIT0 : ST_EMIT1;
         end
         ST_EMIT0: begin
            if (!rsp_stall) state_in = ST_EMIT1;
         end
         ST_EMIT1: begin
            if (!rsp_stall) state_in = req_valid ? ST_DECODE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         ST_DECODE: cmd.decode = 1'b1;
         ST_POP: cmd.pop = 1'b1;
         ST_EMIT0: begin
            rsp_valid = 1'b1;
         end
         ST_EMIT1: begin
            rsp_valid = 1'b1;
            rsp_last = 1'b1;
            cmd.out_sel = 1'b1;
            req_stall = rsp_stall;
            cmd.load = req_valid && !rsp_stall;
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         two_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         two_ff <= two_in;
      end
   end

`ifndef SYNTHESIS
   a_last_only_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT0) |-> !rsp_last) else $error("last on first result");
   a_pop_then_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP && !sts.pop_more) |=> rsp_valid)
      else $error("stack walk not followed by result");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE || state_ff == ST_POP) |-> req_stall)
      else $error("input taken while busy");
`endif

endmodule

// File: sv/rrsp_datapath.sv
// datapath: byte decode, number accumulate, count stack for the parser
module rrsp_datapath import rrsp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic [7:0] req_stream_byte,
   input logic csr_write,
   input logic [0:0] csr_index,
   input logic [26:0] csr_data,
   input cmd_type cmd,
   output sts_type sts,
   output result_type rsp
);

   logic [26:0] max_bulk_ff;
   logic [19:0] max_array_ff;

   logic [7:0] byte_ff;
   phase_type phase_ff, phase_in;
   kind_type kind_ff, kind_in;
   logic held_ff, held_in;
   logic neg_ff, neg_in;
   logic seen_ff, seen_in;
   logic [63:0] mag_ff, mag_in;
   logic [26:0] bulk_ff, bulk_in;
   logic [1:0] trail_ff, trail_in;
   logic [DepthW-1:0] depth_ff, depth_in;
   error_type err_ff, err_in;
   logic [19:0] counts_ff [MaxDepth];

   result_type r0_ff, r0_in, r1_ff, r1_in;
   logic two_in;
   logic pend_ff, pend_in;
   logic push_in;
   logic [19:0] push_val_in;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bulk_ff <= BULK_LIMIT_RESET;
         max_array_ff <= ARRAY_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_BULK: max_bulk_ff <= csr_data;
            CSR_MAX_ARRAY: max_array_ff <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   // digit decode and overflow check: mag*10+d within limit
   logic is_digit;
   logic [3:0] digit;
   logic [67:0] mag10;
   logic [67:0] sum_mag;
   logic [63:0] lim;
   logic ovf;
   logic err_kind_ok;
   error_type num_err;
   logic negv;
   logic [63:0] sval;
   always_comb begin
      is_digit = byte_ff >= CH_ZERO && byte_ff <= CH_NINE;
      digit = 4'(byte_ff - CH_ZERO);
      // mag*8 + mag*2
      mag10 = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0};
      sum_mag = mag10 + 68'(digit);
      lim = INT_TOP + 64'(neg_ff);
      ovf = sum_mag > 68'(lim);
      err_kind_ok = 1'b1;
      num_err = error_type'(kind_ff - 3'd1);
      negv = neg_ff && (mag_ff != 64'd0);
      sval = neg_ff ? (64'd0 - mag_ff) : mag_ff;
   end

   // byte decode
   always_comb begin
      phase_in = phase_ff;
      kind_in = kind_ff;
      held_in = held_ff;
      neg_in = neg_ff;
      seen_in = seen_ff;
      mag_in = mag_ff;
      bulk_in = bulk_ff;
      trail_in = trail_ff;
      err_in = err_ff;
      r0_in = '0;
      r1_in = '0;
      two_in = 1'b0;
      pend_in = 1'b0;
      push_in = 1'b0;
      push_val_in = mag_ff[19:0];
      r1_in.depth = 4'd0;
      unique case (phase_ff)
         PH_TAG: begin
            r1_in.role = ROLE_TAG;
            unique case (byte_ff)
               CH_PLUS: kind_in = KIND_SIMPLE;
               CH_MINUS: kind_in = KIND_ERROR;
               CH_COLON: kind_in = KIND_INT;
               CH_DOLLAR: kind_in = KIND_BULK;
               CH_STAR: kind_in = KIND_ARRAY;
               CH_CR: kind_in = KIND_CRTAG;
               default: kind_in = KIND_NONE;
            endcase
            if (kind_in == KIND_NONE) begin
               kind_in = kind_ff;
               err_in = ERR_UNKNOWN_TAG;
               phase_in = PH_ERR;
               held_in = 1'b0;
               r1_in.role = ROLE_DISCARD;
            end else begin
               held_in = byte_ff == CH_CR;
               neg_in = 1'b0;
               seen_in = 1'b0;
               mag_in = '0;
               phase_in = PH_LINE;
            end
         end
         PH_LINE: begin
            if (kind_ff == KIND_CRTAG) begin
               err_in = (byte_ff == CH_LF) ? ERR_EMPTY : ERR_UNKNOWN_TAG;
               phase_in = PH_ERR;
               held_in = 1'b0;
               r1_in.role = ROLE_DISCARD;
            end else if (kind_ff == KIND_SIMPLE || kind_ff == KIND_ERROR) begin
               if (held_ff && byte_ff == CH_LF) begin
                  held_in = 1'b0;
                  r1_in.role = ROLE_TERM;
                  r1_in.ev = (kind_ff == KIND_SIMPLE) ? EV_SIMPLE_END : EV_ERROR_END;
                  r1_in.depth = depth_ff;
                  pend_in = 1'b1;
                  phase_in = PH_TAG;
               end else begin
                  if (held_ff) begin
                     two_in = 1'b1;
                     r0_in.role = ROLE_HELD_CR;
                     r0_in.content = CH_CR;
                  end
                  if (byte_ff == CH_CR) begin
                     held_in = 1'b1;
                     r1_in.role = ROLE_TERM;
                  end else begin
                     held_in = 1'b0;
                     r1_in.role = ROLE_CONTENT;
                     r1_in.content = byte_ff;
                  end
               end
            end else if (held_ff) begin
               held_in = 1'b0;
               if (byte_ff != CH_LF || !seen_ff) begin
                  err_in = num_err;
                  phase_in = PH_ERR;
                  r1_in.role = ROLE_DISCARD;
               end else begin
                  r1_in.role = ROLE_TERM;
                  phase_in = PH_TAG;
                  if (kind_ff == KIND_INT) begin
                     r1_in.ev = EV_INTEGER;
                     r1_in.value = sval;
                     r1_in.depth = depth_ff;
                     pend_in = 1'b1;
                  end else if (negv) begin
                     r1_in.ev = EV_NIL;
                     r1_in.depth = depth_ff;
                     pend_in = 1'b1;
                  end else if (kind_ff == KIND_BULK) begin
                     if (mag_ff > 64'(max_bulk_ff)) begin
                        err_in = ERR_BAD_BULK;
                        phase_in = PH_ERR;
                        r1_in.role = ROLE_DISCARD;
                     end else begin
                        r1_in.ev = EV_BULK_START;
                        r1_in.value = mag_ff;
                        r1_in.depth = depth_ff;
                        bulk_in = mag_ff[26:0];
                        trail_in = 2'd2;
                        phase_in = (mag_ff == 64'd0) ? PH_TRAIL : PH_BULK;
                     end
                  end else begin
                     if (mag_ff > 64'(max_array_ff)) begin
                        err_in = ERR_BAD_ARRAY;
                        phase_in = PH_ERR;
                        r1_in.role = ROLE_DISCARD;
                     end else if (mag_ff == 64'd0) begin
                        r1_in.ev = EV_ARRAY_START;
                        r1_in.depth = depth_ff;
                        pend_in = 1'b1;
                     end else if (depth_ff >= DepthW'(MaxDepth)) begin
                        err_in = ERR_TOO_DEEP;
                        phase_in = PH_ERR;
                        r1_in.role = ROLE_DISCARD;
                     end else begin
                        r1_in.ev = EV_ARRAY_START;
                        r1_in.value = mag_ff;
                        r1_in.depth = depth_ff;
                        push_in = 1'b1;
                     end
                  end
               end
            end else if (byte_ff == CH_CR) begin
               held_in = 1'b1;
               r1_in.role = ROLE_TERM;
            end else if (byte_ff == CH_MINUS && !neg_ff && !seen_ff) begin
               neg_in = 1'b1;
               r1_in.role = ROLE_CONTENT;
               r1_in.content = byte_ff;
            end else if (is_digit && !ovf && err_kind_ok) begin
               mag_in = sum_mag[63:0];
               seen_in = 1'b1;
               r1_in.role = ROLE_CONTENT;
               r1_in.content = byte_ff;
            end else begin
               err_in = num_err;
               phase_in = PH_ERR;
               r1_in.role = ROLE_DISCARD;
            end
         end
         PH_BULK: begin
            r1_in.role = ROLE_BULK;
            r1_in.content = byte_ff;
            bulk_in = (bulk_ff != 27'd0) ? bulk_ff - 27'd1 : bulk_ff;
            if (bulk_in == 27'd0) begin
               trail_in = 2'd2;
               phase_in = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            r1_in.role = ROLE_TRAIL;
            trail_in = (trail_ff != 2'd0) ? trail_ff - 2'd1 : trail_ff;
            if (trail_in == 2'd0) begin
               r1_in.ev = EV_BULK_END;
               r1_in.depth = depth_ff;
               pend_in = 1'b1;
               phase_in = PH_TAG;
            end
         end
         default: r1_in.role = ROLE_DISCARD;
      endcase
      r0_in.err = err_in;
      r1_in.err = err_in;
      r1_in.done = (depth_ff == '0) && pend_in;
   end

   // stack walk: one count decrement per cycle
   logic [SlotW-1:0] top;
   logic [19:0] top_dec;
   logic pop_close;
   assign top = SlotW'(depth_ff - 4'd1);
   assign top_dec = counts_ff[top] - 20'd1;
   assign pop_close = top_dec == 20'd0;
   assign sts.two = two_in;
   assign sts.need_pop = pend_in && (depth_ff != '0);
   assign sts.pop_more = pend_ff && pop_close && (depth_ff > 4'd1);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         kind_ff <= KIND_NONE;
         held_ff <= 1'b0;
         neg_ff <= 1'b0;
         seen_ff <= 1'b0;
         mag_ff <= '0;
         bulk_ff <= '0;
         trail_ff <= '0;
         depth_ff <= '0;
         err_ff <= ERR_NONE;
         pend_ff <= 1'b0;
      end else if (cmd.decode) begin
         phase_ff <= phase_in;
         kind_ff <= kind_in;
         held_ff <= held_in;
         neg_ff <= neg_in;
         seen_ff <= seen_in;
         mag_ff <= mag_in;
         bulk_ff <= bulk_in;
         trail_ff <= trail_in;
         err_ff <= err_in;
         pend_ff <= pend_in && (depth_ff != '0);
         if (push_in) depth_ff <= depth_ff + 4'd1;
      end else if (cmd.pop && pend_ff) begin
         if (pop_close) depth_ff <= depth_ff - 4'd1;
         else pend_ff <= 1'b0;
         if (pop_close && depth_ff == 4'd1) pend_ff <= 1'b0;
      end
   end

   // count stack
   always_ff @(posedge clock) begin
      if (cmd.decode && push_in) counts_ff[SlotW'(depth_ff)] <= push_val_in;
      else if (cmd.pop && pend_ff) counts_ff[top] <= top_dec;
   end

   // input byte and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) byte_ff <= req_stream_byte;
      if (cmd.decode) begin
         r0_ff <= r0_in;
         r1_ff <= r1_in;
      end else if (cmd.pop && pend_ff && pop_close) begin
         r1_ff.closed <= r1_ff.closed + 4'd1;
         r1_ff.done <= depth_ff == 4'd1;
      end
   end

   assign rsp = cmd.out_sel ? r1_ff : r0_ff;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DepthW'(MaxDepth)) else $error("nesting depth beyond limit");
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE) |=> (err_ff == $past(err_ff)))
      else $error("sticky error changed");
   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE) |-> (phase_ff == PH_ERR)) else $error("error without error phase");
`endif

endmodule
